FILE: hdl/cddn_pkg.sv
// Package for the civil date / day number converter.
// Holds widths, mode codes, calendar tables and the year-base arithmetic.
// Used by every design module of the block but the checker, and by the testbench; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package cddn_pkg;

  localparam int YEAR_W = 14;
  localparam int MON_W  = 4;
  localparam int DOM_W  = 5;
  localparam int CNT_W  = 23;
  localparam int OFS_W  = 22;
  localparam int NUM_W  = 25;
  localparam int BASE_W = 24;
  localparam int YB_W   = 23;
  localparam int DOFF_W = 10;
  localparam int MST_W  = 9;
  localparam int Q_W    = 8;
  localparam int REM_W  = 9;
  localparam int MI_W   = 4;

  localparam int IN_DATA_W  = 72;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 48;
  localparam int OUT_USER_W = 1;

  localparam int DAY_MIN   = -59;
  localparam int DAY_MAX   = 3652364;
  localparam int SAT_MIN   = -4194304;
  localparam int SAT_MAX   = 4194303;
  localparam int DAYS_YEAR = 365;

  localparam logic signed [NUM_W-1:0] NUM_DAY_MIN = NUM_W'(DAY_MIN);
  localparam logic signed [NUM_W-1:0] NUM_DAY_MAX = NUM_W'(DAY_MAX);
  localparam logic signed [NUM_W-1:0] NUM_SAT_MIN = NUM_W'(SAT_MIN);
  localparam logic signed [NUM_W-1:0] NUM_SAT_MAX = NUM_W'(SAT_MAX);
  localparam logic [BASE_W-1:0]       BASE_NEG    = BASE_W'(-DAYS_YEAR);

  localparam logic [12:0] RECIP_100  = 13'd5243;
  localparam int          SHIFT_100  = 19;
  localparam logic [21:0] RECIP_YEAR = 22'd2939805;
  localparam int          SHIFT_YEAR = 30;

  // Month index (March is zero) from which a date falls in the next civil year.
  localparam logic [MI_W-1:0] JAN_IDX = MI_W'(10);

  typedef enum logic [1:0] {
    MODE_TO_NUM  = 2'd0,
    MODE_TO_DATE = 2'd1,
    MODE_ADD     = 2'd2,
    MODE_SUB     = 2'd3
  } mode_t;

  typedef struct packed {
    logic signed [NUM_W-1:0] num;
  } num_word_t;

  function automatic logic [MON_W-1:0] march_month(input logic [MON_W-1:0] month);
    logic [4:0] shifted;
    shifted = 5'(month) + 5'd9;
    if (shifted >= 5'd24) return MON_W'(shifted - 5'd24);
    else if (shifted >= 5'd12) return MON_W'(shifted - 5'd12);
    else return MON_W'(shifted);
  endfunction

  function automatic logic [MST_W-1:0] month_start(input logic [MI_W-1:0] idx);
    logic [MST_W-1:0] start;
    case (idx)
      4'd0:    start = 9'd0;
      4'd1:    start = 9'd31;
      4'd2:    start = 9'd61;
      4'd3:    start = 9'd92;
      4'd4:    start = 9'd122;
      4'd5:    start = 9'd153;
      4'd6:    start = 9'd184;
      4'd7:    start = 9'd214;
      4'd8:    start = 9'd245;
      4'd9:    start = 9'd275;
      4'd10:   start = 9'd306;
      4'd11:   start = 9'd337;
      default: start = 9'd0;
    endcase
    return start;
  endfunction

  function automatic logic [Q_W-1:0] div100(input logic [YEAR_W-1:0] y);
    logic [26:0] prod;
    prod = 27'(y) * 27'(RECIP_100);
    return prod[SHIFT_100 +: Q_W];
  endfunction

  function automatic logic [YB_W-1:0] year_base(input logic [YEAR_W-1:0] y,
                                                input logic [Q_W-1:0]    q100);
    logic [YB_W-1:0] y_ext;
    logic [YB_W-1:0] q_ext;
    y_ext = YB_W'(y);
    q_ext = YB_W'(q100);
    return y_ext * YB_W'(DAYS_YEAR) + (y_ext >> 2) - q_ext + (q_ext >> 2);
  endfunction

  function automatic logic [MI_W-1:0] month_index(input logic [REM_W-1:0] rem);
    logic [15:0]     scaled;
    logic [MI_W-1:0] idx;
    scaled = 16'(rem) * 16'd100 + 16'd52;
    idx    = '0;
    for (int k = 1; k < 12; k++) begin
      if (scaled >= 16'(3060 * k)) idx = MI_W'(k);
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/cddn_day_calc.sv
// Three-stage pipeline that turns a date, a mode and an offset into a day number.
// Depends on cddn_pkg for widths, mode codes and the year-base arithmetic.
`timescale 1ns / 1ps
`default_nettype none

module cddn_day_calc
  import cddn_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire mode_t                    mode,
  input  wire logic [YEAR_W-1:0]        year,
  input  wire logic [MON_W-1:0]         month,
  input  wire logic [DOM_W-1:0]         day,
  input  wire logic signed [CNT_W-1:0]  count_in,
  input  wire logic [OFS_W-1:0]         offset,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output num_word_t                     out_word
);

  localparam int NSTG = 3;

  logic [NSTG-1:0] vld_r, vld_nxt, adv;

  logic [MON_W-1:0]  mm;
  logic              borrow;
  logic              yneg_nxt;
  logic [YEAR_W-1:0] yy_nxt;
  logic [DOFF_W-1:0] doff_nxt;

  logic [YEAR_W-1:0] s1_yy_r;
  logic [Q_W-1:0]    s1_q100_r;
  logic              s1_yneg_r;
  logic [DOFF_W-1:0] s1_doff_r;
  mode_t             s1_mode_r;
  logic [CNT_W-1:0]  s1_cnt_r;
  logic [OFS_W-1:0]  s1_ofs_r;

  logic [BASE_W-1:0] base_nxt;
  logic [BASE_W-1:0] s2_base_r;
  logic [DOFF_W-1:0] s2_doff_r;
  mode_t             s2_mode_r;
  logic [CNT_W-1:0]  s2_cnt_r;
  logic [OFS_W-1:0]  s2_ofs_r;

  logic [NUM_W-1:0]  sum_date, ofs_ext, cnt_ext, num_nxt;
  logic [NUM_W-1:0]  s3_num_r;

  always_comb begin
    adv[NSTG-1] = !vld_r[NSTG-1] || out_ready;
    for (int k = NSTG - 2; k >= 0; k--) adv[k] = !vld_r[k] || adv[k+1];
    for (int k = 0; k < NSTG; k++) begin
      if (adv[k]) vld_nxt[k] = (k == 0) ? in_valid : vld_r[(k == 0) ? 0 : k - 1];
      else vld_nxt[k] = vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = vld_r[NSTG-1];

  always_comb begin
    mm       = march_month(month);
    borrow   = (mm >= JAN_IDX);
    yneg_nxt = borrow && (year == '0);
    yy_nxt   = yneg_nxt ? '0 : year - YEAR_W'(borrow);
    doff_nxt = DOFF_W'(month_start(mm)) + DOFF_W'(day) - DOFF_W'(1);
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s1_yy_r   <= yy_nxt;
      s1_q100_r <= div100(yy_nxt);
      s1_yneg_r <= yneg_nxt;
      s1_doff_r <= doff_nxt;
      s1_mode_r <= mode;
      s1_cnt_r  <= count_in;
      s1_ofs_r  <= offset;
    end
  end

  assign base_nxt = s1_yneg_r ? BASE_NEG : BASE_W'(year_base(s1_yy_r, s1_q100_r));

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s2_base_r <= base_nxt;
      s2_doff_r <= s1_doff_r;
      s2_mode_r <= s1_mode_r;
      s2_cnt_r  <= s1_cnt_r;
      s2_ofs_r  <= s1_ofs_r;
    end
  end

  always_comb begin
    sum_date = {{(NUM_W-BASE_W){s2_base_r[BASE_W-1]}}, s2_base_r}
             + {{(NUM_W-DOFF_W){s2_doff_r[DOFF_W-1]}}, s2_doff_r};
    ofs_ext  = {{(NUM_W-OFS_W){1'b0}}, s2_ofs_r};
    cnt_ext  = {{(NUM_W-CNT_W){s2_cnt_r[CNT_W-1]}}, s2_cnt_r};
    case (s2_mode_r)
      MODE_TO_DATE: num_nxt = cnt_ext;
      MODE_ADD:     num_nxt = sum_date + ofs_ext;
      MODE_SUB:     num_nxt = sum_date - ofs_ext;
      default:      num_nxt = sum_date;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s3_num_r <= num_nxt;
    end
  end

  assign out_word.num = $signed(s3_num_r);

endmodule

`default_nettype wire

FILE: hdl/cddn_date_calc.sv
// Seven-stage pipeline that turns a day number into a date, with range check
// and saturation of the day number. Depends on cddn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cddn_date_calc
  import cddn_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire num_word_t           in_word,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [CNT_W-1:0]         count_out,
  output logic [YEAR_W-1:0]        year_out,
  output logic [MON_W-1:0]         month_out,
  output logic [DOM_W-1:0]         day_out,
  output logic                     oor_out
);

  localparam int NSTG = 7;

  logic [NSTG-1:0] vld_r, vld_nxt, adv;

  logic signed [NUM_W-1:0] num;
  logic                    oor_nxt, nneg_nxt;
  logic [CNT_W-1:0]        sat_nxt, nc_nxt;
  logic [OFS_W-1:0]        nu_nxt;

  logic                    d1_oor_r, d1_nneg_r;
  logic [CNT_W-1:0]        d1_sat_r, d1_nc_r;
  logic [OFS_W-1:0]        d1_nu_r;

  logic [43:0]             prod;
  logic                    d2_oor_r, d2_nneg_r;
  logic [CNT_W-1:0]        d2_sat_r, d2_nc_r;
  logic [YEAR_W-1:0]       d2_ye_r;

  logic [YEAR_W-1:0]       ylo_nxt, yhi_nxt;
  logic                    d3_oor_r, d3_nneg_r;
  logic [CNT_W-1:0]        d3_sat_r, d3_nc_r;
  logic [YEAR_W-1:0]       d3_ylo_r, d3_ymid_r, d3_yhi_r;
  logic [Q_W-1:0]          d3_qlo_r, d3_qmid_r, d3_qhi_r;

  logic                    d4_oor_r, d4_nneg_r;
  logic [CNT_W-1:0]        d4_sat_r, d4_nc_r;
  logic [YEAR_W-1:0]       d4_ylo_r, d4_ymid_r, d4_yhi_r;
  logic [YB_W-1:0]         d4_yblo_r, d4_ybmid_r, d4_ybhi_r;

  logic [YB_W-1:0]         ncu, dlo, dmid, dhi;
  logic [REM_W-1:0]        rem_nxt;
  logic [YEAR_W-1:0]       y_nxt;
  logic                    d5_oor_r, d5_nneg_r;
  logic [CNT_W-1:0]        d5_sat_r;
  logic [YEAR_W-1:0]       d5_y_r;
  logic [REM_W-1:0]        d5_rem_r;

  logic                    d6_oor_r, d6_nneg_r;
  logic [CNT_W-1:0]        d6_sat_r;
  logic [YEAR_W-1:0]       d6_y_r;
  logic [REM_W-1:0]        d6_rem_r;
  logic [MI_W-1:0]         d6_mi_r;

  logic                    carry;
  logic [REM_W-1:0]        dd_full;
  logic [YEAR_W-1:0]       year_nxt;
  logic [MON_W-1:0]        mon_nxt;
  logic [DOM_W-1:0]        dd_nxt;
  logic [CNT_W-1:0]        cnt_r;
  logic [YEAR_W-1:0]       year_r;
  logic [MON_W-1:0]        mon_r;
  logic [DOM_W-1:0]        dd_r;
  logic                    oor_r;

  always_comb begin
    adv[NSTG-1] = !vld_r[NSTG-1] || out_ready;
    for (int k = NSTG - 2; k >= 0; k--) adv[k] = !vld_r[k] || adv[k+1];
    for (int k = 0; k < NSTG; k++) begin
      if (adv[k]) vld_nxt[k] = (k == 0) ? in_valid : vld_r[(k == 0) ? 0 : k - 1];
      else vld_nxt[k] = vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = vld_r[NSTG-1];

  always_comb begin
    num      = in_word.num;
    oor_nxt  = (num < NUM_DAY_MIN) || (num > NUM_DAY_MAX);
    if (num < NUM_SAT_MIN) sat_nxt = NUM_SAT_MIN[CNT_W-1:0];
    else if (num > NUM_SAT_MAX) sat_nxt = NUM_SAT_MAX[CNT_W-1:0];
    else sat_nxt = num[CNT_W-1:0];
    nc_nxt   = oor_nxt ? '0 : num[CNT_W-1:0];
    nneg_nxt = !oor_nxt && num[NUM_W-1];
    nu_nxt   = (oor_nxt || num[NUM_W-1]) ? '0 : num[OFS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      d1_oor_r  <= oor_nxt;
      d1_nneg_r <= nneg_nxt;
      d1_sat_r  <= sat_nxt;
      d1_nc_r   <= nc_nxt;
      d1_nu_r   <= nu_nxt;
    end
  end

  assign prod = 44'(d1_nu_r) * 44'(RECIP_YEAR);

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      d2_oor_r  <= d1_oor_r;
      d2_nneg_r <= d1_nneg_r;
      d2_sat_r  <= d1_sat_r;
      d2_nc_r   <= d1_nc_r;
      d2_ye_r   <= prod[SHIFT_YEAR +: YEAR_W];
    end
  end

  assign ylo_nxt = (d2_ye_r == '0) ? '0 : d2_ye_r - YEAR_W'(1);
  assign yhi_nxt = d2_ye_r + YEAR_W'(1);

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      d3_oor_r  <= d2_oor_r;
      d3_nneg_r <= d2_nneg_r;
      d3_sat_r  <= d2_sat_r;
      d3_nc_r   <= d2_nc_r;
      d3_ylo_r  <= ylo_nxt;
      d3_ymid_r <= d2_ye_r;
      d3_yhi_r  <= yhi_nxt;
      d3_qlo_r  <= div100(ylo_nxt);
      d3_qmid_r <= div100(d2_ye_r);
      d3_qhi_r  <= div100(yhi_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      d4_oor_r   <= d3_oor_r;
      d4_nneg_r  <= d3_nneg_r;
      d4_sat_r   <= d3_sat_r;
      d4_nc_r    <= d3_nc_r;
      d4_ylo_r   <= d3_ylo_r;
      d4_ymid_r  <= d3_ymid_r;
      d4_yhi_r   <= d3_yhi_r;
      d4_yblo_r  <= year_base(d3_ylo_r, d3_qlo_r);
      d4_ybmid_r <= year_base(d3_ymid_r, d3_qmid_r);
      d4_ybhi_r  <= year_base(d3_yhi_r, d3_qhi_r);
    end
  end

  always_comb begin
    ncu  = {1'b0, d4_nc_r[OFS_W-1:0]};
    dlo  = ncu - d4_yblo_r;
    dmid = ncu - d4_ybmid_r;
    dhi  = ncu - d4_ybhi_r;
    if (d4_nneg_r) begin
      y_nxt   = '0;
      rem_nxt = d4_nc_r[REM_W-1:0] + REM_W'(DAYS_YEAR);
    end else if (ncu < d4_ybmid_r) begin
      y_nxt   = d4_ylo_r;
      rem_nxt = dlo[REM_W-1:0];
    end else if (ncu >= d4_ybhi_r) begin
      y_nxt   = d4_yhi_r;
      rem_nxt = dhi[REM_W-1:0];
    end else begin
      y_nxt   = d4_ymid_r;
      rem_nxt = dmid[REM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      d5_oor_r  <= d4_oor_r;
      d5_nneg_r <= d4_nneg_r;
      d5_sat_r  <= d4_sat_r;
      d5_y_r    <= y_nxt;
      d5_rem_r  <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      d6_oor_r  <= d5_oor_r;
      d6_nneg_r <= d5_nneg_r;
      d6_sat_r  <= d5_sat_r;
      d6_y_r    <= d5_y_r;
      d6_rem_r  <= d5_rem_r;
      d6_mi_r   <= month_index(d5_rem_r);
    end
  end

  always_comb begin
    carry   = (d6_mi_r >= JAN_IDX);
    dd_full = d6_rem_r - month_start(d6_mi_r) + REM_W'(1);
    if (d6_oor_r) begin
      year_nxt = '0;
      mon_nxt  = '0;
      dd_nxt   = '0;
    end else begin
      year_nxt = d6_nneg_r ? '0 : d6_y_r + YEAR_W'(carry);
      mon_nxt  = carry ? MON_W'(d6_mi_r - MI_W'(9)) : MON_W'(d6_mi_r + MI_W'(3));
      dd_nxt   = dd_full[DOM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      cnt_r  <= d6_sat_r;
      year_r <= year_nxt;
      mon_r  <= mon_nxt;
      dd_r   <= dd_nxt;
      oor_r  <= d6_oor_r;
    end
  end

  assign count_out = cnt_r;
  assign year_out  = year_r;
  assign month_out = mon_r;
  assign day_out   = dd_r;
  assign oor_out   = oor_r;

endmodule

`default_nettype wire

FILE: hdl/civil_date_day_number_converter.sv
// Top level of the civil date / day number converter; instantiates the day
// number pipeline and the date pipeline, and depends on cddn_pkg.
// An accepted input word passes through the day number pipeline and then the date pipeline.
// Throughput is one word per clock cycle while the output is not stalled; each stage holds its word on a stall.
// Synchronous active-low reset clears all valid bits; data registers keep their values.
`timescale 1ns / 1ps
`default_nettype none

module civil_date_day_number_converter
  import cddn_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // year, month, day, day_count_in, offset_days, zero padding
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // mode
  input  wire logic [IN_USER_W-1:0]  in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // day_count_out, year_out, month_out, day_out, zero padding
  output logic [OUT_DATA_W-1:0]      out_tdata,
  // out_of_range
  output logic [OUT_USER_W-1:0]      out_tuser
);

  logic              num_valid, num_ready;
  num_word_t         num_word;
  logic [CNT_W-1:0]  count_out;
  logic [YEAR_W-1:0] year_out;
  logic [MON_W-1:0]  month_out;
  logic [DOM_W-1:0]  day_out;
  logic              oor_out;

  cddn_day_calc u_day (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .mode      (mode_t'(in_tuser[1:0])),
    .year      (in_tdata[13:0]),
    .month     (in_tdata[17:14]),
    .day       (in_tdata[22:18]),
    .count_in  ($signed(in_tdata[45:23])),
    .offset    (in_tdata[67:46]),
    .out_valid (num_valid),
    .out_ready (num_ready),
    .out_word  (num_word)
  );

  cddn_date_calc u_date (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (num_valid),
    .in_ready  (num_ready),
    .in_word   (num_word),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .count_out (count_out),
    .year_out  (year_out),
    .month_out (month_out),
    .day_out   (day_out),
    .oor_out   (oor_out)
  );

  assign out_tdata = {2'b00, day_out, month_out, year_out, count_out};
  assign out_tuser = oor_out;

endmodule

`default_nettype wire

FILE: hdl/cddn_checker.sv
// Port-level checker for the civil date / day number converter, bound to the
// top level. Depends on nothing but the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module cddn_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [71:0] in_tdata,
  input wire logic [1:0]  in_tuser,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [47:0] out_tdata,
  input wire logic [0:0]  out_tuser
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output word valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled output word changed");

  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |->
      out_tdata[45:23] == 23'd0 &&
      ($signed(out_tdata[22:0]) < -59 || $signed(out_tdata[22:0]) > 3652364))
    else $error("out-of-range word with date fields or in-range day number");

  a_date_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |->
      out_tdata[40:37] >= 4'd1 && out_tdata[40:37] <= 4'd12 &&
      out_tdata[45:41] >= 5'd1 &&
      $signed(out_tdata[22:0]) >= -59 && $signed(out_tdata[22:0]) <= 3652364)
    else $error("in-range word with bad month, day or day number");

endmodule

bind civil_date_day_number_converter cddn_checker u_cddn_checker (.*);

`default_nettype wire

FILE: verif/tb_civil_date_day_number_converter.sv
// Self-checking testbench for civil_date_day_number_converter: directed table, then random words
// under random stalls on both stream sides, checked against a behavioral calendar predictor.
// Depends on cddn_pkg and the converter RTL only.
`timescale 1ns / 1ps

module tb_civil_date_day_number_converter;
  import cddn_pkg::*;

  localparam int N_RANDOM    = 1700;
  localparam int N_QUIET     = 300;
  localparam int DRAIN_AT    = 600;
  localparam int HOLD_AT     = 900;
  localparam int HOLD_WORDS  = 40;
  localparam int LONG_HOLD   = 300;
  localparam int TAIL_CYCLES = 40;
  localparam int CYCLE_LIMIT = 500000;

  typedef struct packed {
    mode_t             mode;
    logic [YEAR_W-1:0] year;
    logic [MON_W-1:0]  month;
    logic [DOM_W-1:0]  day;
    logic [CNT_W-1:0]  cnt;
    logic [OFS_W-1:0]  ofs;
  } date_word_t;

  typedef struct packed {
    logic [CNT_W-1:0]  cnt;
    logic [YEAR_W-1:0] year;
    logic [MON_W-1:0]  month;
    logic [DOM_W-1:0]  day;
    logic              oor;
  } calendar_t;

  typedef struct packed {
    date_word_t word;
    logic       typed;
    calendar_t  want;
  } table_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [IN_USER_W-1:0]  in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;

  calendar_t   pending_dates[$];
  table_row_t  directed_rows[$];
  int          mismatch_count = 0;
  int          results_seen = 0;
  int          oor_seen = 0;
  int          mode_hits[4] = '{0, 0, 0, 0};
  int unsigned cycle_count = 0;
  bit          quiet = 1'b0;
  bit          hold_req = 1'b0;
  calendar_t   got_date;
  calendar_t   want_date;

  civil_date_day_number_converter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Days from 0000-03-01 to March 1 of the March-based year y.
  function automatic longint march_year_start(input longint y);
    return 365 * y + y / 4 - y / 100 + y / 400;
  endfunction

  function automatic calendar_t convert_calendar_word(input date_word_t w);
    longint    n, y, rem, mi, mm;
    calendar_t r;
    r = '0;
    if (w.mode == MODE_TO_DATE) begin
      n = longint'($signed(w.cnt));
    end else begin
      mm = (longint'(w.month) + 9) % 12;
      n = march_year_start(longint'(w.year) - mm / 10) + (mm * 306 + 5) / 10
          + longint'(w.day) - 1;
      if (w.mode == MODE_ADD) n = n + longint'(w.ofs);
      else if (w.mode == MODE_SUB) n = n - longint'(w.ofs);
    end
    r.oor = (n < DAY_MIN) || (n > DAY_MAX);
    if (!r.oor) begin
      y = (10000 * n + 14780) / 3652425;
      rem = n - march_year_start(y);
      if (rem < 0) begin
        y = y - 1;
        rem = n - march_year_start(y);
      end
      mi = (100 * rem + 52) / 3060;
      r.month = MON_W'((mi + 2) % 12 + 1);
      r.year = YEAR_W'(y + (mi + 2) / 12);
      r.day = DOM_W'(rem - (mi * 306 + 5) / 10 + 1);
    end
    if (n < SAT_MIN) n = SAT_MIN;
    if (n > SAT_MAX) n = SAT_MAX;
    r.cnt = CNT_W'(n);
    return r;
  endfunction

  function automatic date_word_t random_date_word();
    date_word_t w;
    w.mode = mode_t'($urandom_range(0, 3));
    case ($urandom_range(0, 7))
      0:       w.year = YEAR_W'($urandom_range(0, 3));
      1:       w.year = YEAR_W'($urandom_range(9996, 9999));
      default: w.year = YEAR_W'($urandom_range(0, 9999));
    endcase
    if ($urandom_range(0, 9) == 0) w.month = MON_W'($urandom_range(0, 15));
    else w.month = MON_W'($urandom_range(1, 12));
    case ($urandom_range(0, 9))
      0:       w.day = DOM_W'($urandom_range(0, 31));
      1, 2:    w.day = DOM_W'($urandom_range(29, 31));
      default: w.day = DOM_W'($urandom_range(1, 28));
    endcase
    case ($urandom_range(0, 9))
      0:       w.cnt = CNT_W'($urandom_range(0, 40) - 60);
      1:       w.cnt = CNT_W'($urandom_range(3652340, 3652380));
      2:       w.cnt = CNT_W'($urandom);
      default: w.cnt = CNT_W'($urandom_range(0, 3652423) - 59);
    endcase
    case ($urandom_range(0, 5))
      0:       w.ofs = OFS_W'($urandom_range(0, 400));
      1:       w.ofs = OFS_W'($urandom_range(3652000, 3652423));
      default: w.ofs = OFS_W'($urandom_range(0, 3652423));
    endcase
    return w;
  endfunction

  task automatic add_row(input mode_t m, input int yr, input int mo, input int dy,
                         input int cnt, input int ofs, input bit typed = 1'b0,
                         input int e_cnt = 0, input int e_yr = 0, input int e_mo = 0,
                         input int e_dy = 0, input bit e_oor = 1'b0);
    table_row_t row;
    row.word  = '{m, YEAR_W'(yr), MON_W'(mo), DOM_W'(dy), CNT_W'(cnt), OFS_W'(ofs)};
    row.typed = typed;
    row.want  = '{CNT_W'(e_cnt), YEAR_W'(e_yr), MON_W'(e_mo), DOM_W'(e_dy), e_oor};
    directed_rows.push_back(row);
  endtask

  task automatic send_word(input date_word_t w, input calendar_t want);
    in_tvalid <= 1'b1;
    in_tdata  <= IN_DATA_W'({w.ofs, w.cnt, w.day, w.month, w.year});
    in_tuser  <= w.mode;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_dates.push_back(want);
    mode_hits[w.mode]++;
  endtask

  task automatic sender_gap();
    in_tvalid <= 1'b0;
    repeat ($urandom_range(1, 14)) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic signed [CNT_W:0] e,
                             input logic signed [CNT_W:0] g);
    if (g !== e) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, e, g);
    end
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d words still pending", cycle_count,
               pending_dates.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_date.cnt   = out_tdata[CNT_W-1:0];
      got_date.year  = out_tdata[CNT_W +: YEAR_W];
      got_date.month = out_tdata[CNT_W+YEAR_W +: MON_W];
      got_date.day   = out_tdata[CNT_W+YEAR_W+MON_W +: DOM_W];
      got_date.oor   = out_tuser[0];
      results_seen++;
      if (pending_dates.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result word, got %h / %b", $time, out_tdata, out_tuser);
      end else begin
        want_date = pending_dates.pop_front();
        if (want_date.oor) oor_seen++;
        check_field("day_count_out", $signed(want_date.cnt), $signed(got_date.cnt));
        check_field("year_out", want_date.year, got_date.year);
        check_field("month_out", want_date.month, got_date.month);
        check_field("day_out", want_date.day, got_date.day);
        check_field("out_of_range", want_date.oor, got_date.oor);
      end
    end
  end

  initial begin
    int rx_stall;
    rx_stall = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end else if (rx_stall > 0) begin
        out_tready <= 1'b0;
        rx_stall--;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        rx_stall = $urandom_range(1, 14) - 1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    date_word_t w;
    calendar_t  want;

    // Extremes, normalization of odd dates, year zero, saturation, ignored fields.
    add_row(MODE_TO_NUM, 0, 3, 1, 0, 0, 1, 0, 0, 3, 1);
    add_row(MODE_TO_NUM, 0, 1, 1, 0, 0, 1, -59, 0, 1, 1);
    add_row(MODE_TO_NUM, 9999, 12, 31, 0, 0, 1, 3652364, 9999, 12, 31);
    add_row(MODE_TO_DATE, 0, 0, 0, -59, 0, 1, -59, 0, 1, 1);
    add_row(MODE_TO_DATE, 0, 0, 0, 3652364, 0, 1, 3652364, 9999, 12, 31);
    add_row(MODE_TO_DATE, 0, 0, 0, -60, 0, 1, -60, 0, 0, 0, 1);
    add_row(MODE_TO_DATE, 0, 0, 0, 3652365, 0, 1, 3652365, 0, 0, 0, 1);
    add_row(MODE_TO_DATE, 0, 0, 0, -4194304, 0, 1, -4194304, 0, 0, 0, 1);
    add_row(MODE_TO_DATE, 0, 0, 0, 4194303, 0, 1, 4194303, 0, 0, 0, 1);
    add_row(MODE_TO_DATE, 9999, 15, 31, 0, 3652423, 1, 0, 0, 3, 1);
    add_row(MODE_TO_NUM, 0, 2, 29, 0, 0, 1, 0, 0, 3, 1);
    add_row(MODE_TO_NUM, 2001, 2, 30, 0, 0);
    add_row(MODE_TO_NUM, 2000, 2, 29, 0, 0);
    add_row(MODE_TO_NUM, 1900, 2, 29, 0, 0);
    add_row(MODE_TO_NUM, 2000, 0, 1, 0, 0);
    add_row(MODE_TO_NUM, 9999, 15, 31, 0, 0);
    add_row(MODE_TO_NUM, 0, 13, 0, 0, 0);
    add_row(MODE_TO_NUM, 1234, 6, 15, -1, 3652423);
    add_row(MODE_ADD, 0, 1, 1, 0, 3652423, 1, 3652364, 9999, 12, 31);
    add_row(MODE_ADD, 9999, 12, 31, 0, 1, 1, 3652365, 0, 0, 0, 1);
    add_row(MODE_ADD, 9999, 15, 31, 0, 3652423, 1, 4194303, 0, 0, 0, 1);
    add_row(MODE_ADD, 2024, 2, 28, -59, 1);
    add_row(MODE_SUB, 9999, 12, 31, 0, 3652423, 1, -59, 0, 1, 1);
    add_row(MODE_SUB, 0, 1, 1, 0, 1, 1, -60, 0, 0, 0, 1);
    add_row(MODE_SUB, 0, 0, 0, 3652364, 3652423);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      want = directed_rows[i].typed ? directed_rows[i].want
                                    : convert_calendar_word(directed_rows[i].word);
      send_word(directed_rows[i].word, want);
    end

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == DRAIN_AT) begin
        in_tvalid <= 1'b0;
        while (pending_dates.size() != 0) @(posedge clk);
      end
      if (i == HOLD_AT) hold_req = 1'b1;
      quiet = (i >= N_RANDOM - N_QUIET);
      w = random_date_word();
      send_word(w, convert_calendar_word(w));
      if (!quiet && (i < HOLD_AT || i >= HOLD_AT + HOLD_WORDS) && $urandom_range(0, 5) == 0)
        sender_gap();
    end
    in_tvalid <= 1'b0;

    while (pending_dates.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Checked %0d result words (%0d out of range) in %0d cycles.", results_seen,
             oor_seen, cycle_count);
    $display("Words per mode: to number %0d, to date %0d, add %0d, subtract %0d.",
             mode_hits[MODE_TO_NUM], mode_hits[MODE_TO_DATE], mode_hits[MODE_ADD],
             mode_hits[MODE_SUB]);
    if (mismatch_count == 0 && pending_dates.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/cddn_pkg.sv
hdl/cddn_day_calc.sv
hdl/cddn_date_calc.sv
hdl/civil_date_day_number_converter.sv
hdl/cddn_checker.sv
verif/tb_civil_date_day_number_converter.sv
